### rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`default_nettype none

package spq_pkg;

  localparam int TAG_W = 16;
  localparam int LVL_W = 2;
  localparam int OCC_W = 5;
  localparam int ST_W  = 2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [ST_W-1:0] ST_PUSHED = 2'd0;
  localparam logic [ST_W-1:0] ST_POPPED = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

  // One stored entry.
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [LVL_W-1:0] level;
  } entry_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic   push_en;
    logic   pop_en;
    entry_t new_entry;
  } cell_ctrl_t;

  // Where a cell sits relative to the fill count.
  typedef struct packed {
    logic occupied;
    logic at_end;
  } cell_pos_t;

endpackage

`default_nettype wire

### rtl/spq_cell.sv
// One slot of the queue chain: holds an entry, shifts in from either neighbour.
`default_nettype none

module spq_cell (
  input  wire                 clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::cell_pos_t  pos,
  input  wire                 lt_left,
  input  spq_pkg::entry_t     left_entry,
  input  spq_pkg::entry_t     right_entry,
  output logic                lt_here,
  output spq_pkg::entry_t     entry
);
  import spq_pkg::*;

  entry_t entry_next;
  logic   take_new;

  // Entries are held in descending priority from cell 0; the new one goes
  // ahead of the first stored entry with a strictly lower level.
  assign lt_here  = pos.occupied && (entry.level < ctrl.new_entry.level);
  assign take_new = (lt_here || pos.at_end) && !lt_left;

  always_comb begin
    entry_next = entry;
    if (ctrl.push_en) begin
      if (take_new) begin
        entry_next = ctrl.new_entry;
      end else if (lt_left) begin
        entry_next = left_entry;
      end
    end else if (ctrl.pop_en) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

### rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell chain, fill count, result register.
//
// Input channel (in_valid/in_ready): one transaction carries op, entry_tag and
// level. op OP_PUSH stores the entry, op OP_POP serves the most urgent entry,
// oldest first among equal levels.
// Output channel (out_valid/out_ready): exactly one result per input
// transaction, in order: status, served_tag, served_level, occupancy.
// Result timing: the result is registered and shows in the cycle after acceptance.
// Throughput: one transaction per cycle while the output is not stalled. Every
// cell compares its own level against the incoming one and shifts in the same
// cycle, so the chain update and the single result register set the rate; no loop spans cycles.
// Stall: in_ready = !out_valid || out_ready, so while a result is held the
// input is stalled until it is taken; nothing is dropped meanwhile.
// Reset (rst, synchronous): the fill count and out_valid clear; slot
// contents are left as they are and are never seen until written.
// A push when full or a pop when empty leaves the queue untouched and
// reports ST_FULL / ST_EMPTY with served fields at zero.
`default_nettype none

module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          op,
  input  wire  [spq_pkg::TAG_W-1:0]    entry_tag,
  input  wire  [spq_pkg::LVL_W-1:0]    level,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [spq_pkg::ST_W-1:0]     status,
  output logic [spq_pkg::TAG_W-1:0]    served_tag,
  output logic [spq_pkg::LVL_W-1:0]    served_level,
  output logic [spq_pkg::OCC_W-1:0]    occupancy
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             in_fire;
  logic             full;
  logic             empty;
  cell_ctrl_t       ctrl;

  entry_t cell_entry [QUEUE_DEPTH];
  logic   cell_lt    [QUEUE_DEPTH];

  logic [ST_W-1:0]  status_next;
  logic [TAG_W-1:0] served_tag_next;
  logic [LVL_W-1:0] served_level_next;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);

  assign ctrl.push_en             = in_fire && (op == OP_PUSH) && !full;
  assign ctrl.pop_en              = in_fire && (op == OP_POP) && !empty;
  assign ctrl.new_entry.tag       = entry_tag;
  assign ctrl.new_entry.level     = level;

  // Chain of cells; cell 0 holds the entry served next.
  for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
    cell_pos_t pos;
    logic      lt_left;
    entry_t    left_entry;
    entry_t    right_entry;

    assign pos.occupied = (CNT_W'(j) < count);
    assign pos.at_end   = (CNT_W'(j) == count);

    if (j == 0) begin : g_head
      assign lt_left    = 1'b0;
      assign left_entry = ctrl.new_entry;
    end else begin : g_body
      assign lt_left    = cell_lt[j-1];
      assign left_entry = cell_entry[j-1];
    end

    // Tail cell has no right neighbour; what it loads on pop is never read.
    if (j == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[j];
    end else begin : g_inner
      assign right_entry = cell_entry[j+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (pos),
      .lt_left    (lt_left),
      .left_entry (left_entry),
      .right_entry(right_entry),
      .lt_here    (cell_lt[j]),
      .entry      (cell_entry[j])
    );
  end

  // Result and fill count for the accepted transaction.
  always_comb begin
    count_next        = count;
    status_next       = ST_PUSHED;
    served_tag_next   = '0;
    served_level_next = '0;
    if (op == OP_PUSH) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_next = ST_EMPTY;
      end else begin
        status_next       = ST_POPPED;
        served_tag_next   = cell_entry[0].tag;
        served_level_next = cell_entry[0].level;
        count_next        = count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      status       <= status_next;
      served_tag   <= served_tag_next;
      served_level <= served_level_next;
      occupancy    <= OCC_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count above queue depth");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.push_en |=> count == CNT_W'($past(count) + CNT_W'(1)))
    else $error("push did not raise fill count");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop_en |=> count == CNT_W'($past(count) - CNT_W'(1)))
    else $error("pop did not lower fill count");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted transaction gave no result");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    count >= CNT_W'(2) |-> cell_entry[0].level >= cell_entry[1].level)
    else $error("head cells out of priority order");

endmodule

`default_nettype wire

### test/sorted_priority_queue_tb.sv
// Self-checking testbench for the sorted priority queue: random and directed push/pop traffic.
`timescale 1ns / 100ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int RANDOM_ITEMS = 700;
  localparam int QUIET_TAIL   = 80;   // last transactions are sent without idling
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic             op;
    logic [TAG_W-1:0] tag;
    logic [LVL_W-1:0] lvl;
  } request_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [TAG_W-1:0] tag;
    logic [LVL_W-1:0] lvl;
    logic [OCC_W-1:0] occ;
  } queue_result_t;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             in_valid     = 1'b0;
  logic             in_ready;
  logic             op           = OP_PUSH;
  logic [TAG_W-1:0] entry_tag    = '0;
  logic [LVL_W-1:0] level        = '0;
  logic             out_valid;
  logic             out_ready    = 1'b0;
  logic [ST_W-1:0]  status;
  logic [TAG_W-1:0] served_tag;
  logic [LVL_W-1:0] served_level;
  logic [OCC_W-1:0] occupancy;

  // Shadow copy of the queue contents, kept in ascending priority order.
  logic [TAG_W-1:0] held_tag   [QUEUE_DEPTH];
  logic [LVL_W-1:0] held_level [QUEUE_DEPTH];
  int               held_count = 0;

  request_t         pending_requests[$];
  queue_result_t    awaited_results[$];
  int               mismatch_count = 0;
  int               gap_left       = 0;
  int               stall_left     = 0;

  sorted_priority_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .entry_tag    (entry_tag),
    .level        (level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .served_tag   (served_tag),
    .served_level (served_level),
    .occupancy    (occupancy)
  );

  always #6 clk = ~clk;

  // Applies one accepted transaction to the shadow queue and returns its result.
  function automatic queue_result_t queue_update(input logic is_pop,
                                                 input logic [TAG_W-1:0] t,
                                                 input logic [LVL_W-1:0] l);
    queue_result_t r;
    int            slot;
    r = '0;
    if (is_pop == OP_PUSH) begin
      if (held_count >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // insert ahead of the first entry of equal or higher priority
        slot = held_count;
        for (int i = held_count - 1; i >= 0; i--) begin
          if (l <= held_level[i]) slot = i;
        end
        for (int i = held_count; i > slot; i--) begin
          held_tag[i]   = held_tag[i-1];
          held_level[i] = held_level[i-1];
        end
        held_tag[slot]   = t;
        held_level[slot] = l;
        held_count++;
        r.status = ST_PUSHED;
      end
    end else if (held_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      held_count--;
      r.status = ST_POPPED;
      r.tag    = held_tag[held_count];
      r.lvl    = held_level[held_count];
    end
    r.occ = OCC_W'(held_count);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $realtime);
    mismatch_count++;
  endtask

  task automatic add_request(input logic o, input logic [TAG_W-1:0] t,
                             input logic [LVL_W-1:0] l);
    request_t req;
    req.op  = o;
    req.tag = t;
    req.lvl = l;
    pending_requests.push_back(req);
  endtask

  // Driver: presents queued requests, holds each until accepted, idles in bursts.
  always @(posedge clk) begin
    request_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready)
        awaited_results.push_back(queue_update(op, entry_tag, level));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_requests.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 10);
          in_valid <= 1'b0;
        end else begin
          nxt = pending_requests.pop_front();
          in_valid  <= 1'b1;
          op        <= nxt.op;
          entry_tag <= nxt.tag;
          level     <= nxt.lvl;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest prediction.
  always @(posedge clk) begin
    queue_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result, status", 0, status);
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.status)
            report_mismatch("status", want.status, status);
          if (served_tag !== want.tag)
            report_mismatch("served_tag", want.tag, served_tag);
          if (served_level !== want.lvl)
            report_mismatch("served_level", want.lvl, served_level);
          if (occupancy !== want.occ)
            report_mismatch("occupancy", want.occ, occupancy);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (pending_requests.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int push_pct;
    int seg_len;
    int made;

    // Directed: pop when empty, fill to the top with extreme tags and every level,
    // push when full, pops with junk in the ignored fields, refill one slot.
    add_request(OP_POP, 16'hFFFF, 2'd3);
    add_request(OP_PUSH, 16'h0000, 2'd0);
    add_request(OP_PUSH, 16'hFFFF, 2'd3);
    add_request(OP_PUSH, 16'h1111, 2'd1);
    add_request(OP_PUSH, 16'h2222, 2'd2);
    add_request(OP_PUSH, 16'h1112, 2'd1);
    add_request(OP_PUSH, 16'h2223, 2'd2);
    add_request(OP_PUSH, 16'h0001, 2'd0);
    add_request(OP_PUSH, 16'hFFFE, 2'd3);
    for (int i = 0; i < 8; i++)
      add_request(OP_PUSH, TAG_W'(16'hA000 + i), LVL_W'(i % 4));
    add_request(OP_PUSH, 16'hFFFF, 2'd2);
    add_request(OP_POP, 16'hFFFF, 2'd3);
    add_request(OP_POP, 16'h5555, 2'd2);
    add_request(OP_POP, 16'hAAAA, 2'd1);
    add_request(OP_PUSH, 16'h8000, 2'd0);

    // Random: segments biased to fill, to drain, or balanced, so that full and
    // empty are both visited over and over.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      seg_len = $urandom_range(10, 60);
      for (int i = 0; i < seg_len && made < RANDOM_ITEMS; i++) begin
        add_request(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP,
                    TAG_W'($urandom_range(0, 65535)), LVL_W'($urandom_range(0, 3)));
        made++;
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
